[rtl/tbsfd_pkg.sv]
package tbsfd_pkg;

    localparam int CHANNELS_DEF = 16;

    localparam int CODE_W      = 16;
    localparam int GAIN_W      = 16;
    localparam int OFFSET_W    = 17;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 1;
    localparam int UV_W        = 21;
    localparam int EVENT_W     = 6;
    localparam int PROD_W      = CODE_W + GAIN_W;
    localparam int SCALE_SHIFT = 12;
    localparam int SLOT_CMP_W  = 7;

    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd12498;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 17'd98800;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'd1;

    // third byte bits 5:2 all ones close a frame
    localparam logic [3:0] FRAME_MARK = 4'hF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MULT,
        ST_LOAD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic word_we;
        logic rd_issue;
        logic mul_en;
        logic out_load;
        logic next_ch;
        logic frame_clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic last_ch;
    } dp_status_t;

endpackage

[rtl/tbsfd_ctrl.sv]
module tbsfd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  tbsfd_pkg::dp_status_t status,
    output tbsfd_pkg::ctrl_cmd_t  cmd
);

    tbsfd_pkg::state_t state_reg;
    tbsfd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tbsfd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            tbsfd_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.word_we = in_valid;
                if (in_valid && status.frame_end)
                begin
                    state_next = tbsfd_pkg::ST_READ;
                end
            end
            tbsfd_pkg::ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = tbsfd_pkg::ST_MULT;
            end
            tbsfd_pkg::ST_MULT:
            begin
                cmd.mul_en = 1'b1;
                state_next = tbsfd_pkg::ST_LOAD;
            end
            tbsfd_pkg::ST_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = tbsfd_pkg::ST_OUT;
            end
            tbsfd_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (status.last_ch)
                    begin
                        cmd.frame_clear = 1'b1;
                        state_next      = tbsfd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_ch = 1'b1;
                        state_next  = tbsfd_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = tbsfd_pkg::ST_IDLE;
            end
        endcase
    end

    // no new word while a frame is being flushed
    a_valid_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open during flush");

    a_frame_end_starts_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && status.frame_end) |=> (in_stall && !out_valid))
        else $error("frame end did not start flush");

    a_plain_word_keeps_open: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !status.frame_end) |=> !in_stall)
        else $error("plain word closed input");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && status.last_ch) |=> (!in_stall && !out_valid))
        else $error("flush did not end after last sample");

endmodule

[rtl/tbsfd_dp.sv]
module tbsfd_dp #(
    parameter int CHANNELS = tbsfd_pkg::CHANNELS_DEF,
    parameter int IDX_W    = $clog2(CHANNELS)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tbsfd_pkg::ctrl_cmd_t                   cmd,
    output tbsfd_pkg::dp_status_t                  status,
    input  logic [7:0]                             first_byte,
    input  logic [7:0]                             second_byte,
    input  logic [7:0]                             third_byte,
    input  logic                                   cfg_we,
    input  logic [tbsfd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tbsfd_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic [IDX_W-1:0]                       channel_index,
    output logic [tbsfd_pkg::CODE_W-1:0]           sample_code,
    output logic signed [tbsfd_pkg::UV_W-1:0]      sample_microvolts_q4,
    output logic [tbsfd_pkg::EVENT_W-1:0]          event_code,
    output logic                                   last
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    // configuration
    logic [tbsfd_pkg::GAIN_W-1:0]   gain_reg;
    logic [tbsfd_pkg::OFFSET_W-1:0] offset_reg;

    // frame state
    logic [IDX_W-1:0]               word_idx_reg, word_idx_next;
    logic                           wrapped_reg, wrapped_next;
    logic [tbsfd_pkg::EVENT_W-1:0]  event_reg, event_next;
    logic [IDX_W-1:0]               ch_reg, ch_next;

    // sample store with per-entry valid bits, unwritten entries read as zero
    logic [tbsfd_pkg::CODE_W-1:0]   mem_store [CHANNELS];
    logic [CHANNELS-1:0]            written_reg;
    logic [tbsfd_pkg::CODE_W-1:0]   rd_data_reg;
    logic                           rd_hit_reg;
    logic [tbsfd_pkg::CODE_W-1:0]   rd_code;

    logic [tbsfd_pkg::PROD_W-1:0]   prod_reg;
    logic [tbsfd_pkg::UV_W-1:0]     uv_next;

    logic [tbsfd_pkg::CODE_W-1:0]   word_code;
    logic                           ttl;
    logic [tbsfd_pkg::SLOT_CMP_W-1:0] slot_wide;

    assign word_code = {third_byte[1:0], second_byte[6:0], first_byte[6:0]};
    assign ttl       = third_byte[2];
    assign slot_wide = tbsfd_pkg::SLOT_CMP_W'(word_idx_reg);

    assign status.frame_end = (third_byte[5:2] == tbsfd_pkg::FRAME_MARK);
    assign status.last_ch   = (ch_reg == LAST_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= tbsfd_pkg::GAIN_RESET;
            offset_reg <= tbsfd_pkg::OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbsfd_pkg::REG_GAIN:   gain_reg   <= cfg_data[tbsfd_pkg::GAIN_W-1:0];
                tbsfd_pkg::REG_OFFSET: offset_reg <= cfg_data[tbsfd_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        word_idx_next = word_idx_reg;
        wrapped_next  = wrapped_reg;
        event_next    = event_reg;
        ch_next       = ch_reg;
        if (cmd.word_we)
        begin
            // ttl bits only on the first pass, slot k sets bit k-1
            for (int j = 0; j < tbsfd_pkg::EVENT_W; j++)
            begin
                if (!wrapped_reg && (slot_wide == tbsfd_pkg::SLOT_CMP_W'(j + 1)))
                begin
                    event_next[j] = event_reg[j] | ttl;
                end
            end
            if (!status.frame_end)
            begin
                if (word_idx_reg == LAST_IDX)
                begin
                    word_idx_next = '0;
                    wrapped_next  = 1'b1;
                end
                else
                begin
                    word_idx_next = word_idx_reg + 1'b1;
                end
            end
        end
        if (cmd.next_ch)
        begin
            ch_next = ch_reg + 1'b1;
        end
        if (cmd.frame_clear)
        begin
            word_idx_next = '0;
            wrapped_next  = 1'b0;
            event_next    = '0;
            ch_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_idx_reg <= '0;
            wrapped_reg  <= 1'b0;
            event_reg    <= '0;
            ch_reg       <= '0;
            written_reg  <= '0;
        end
        else
        begin
            word_idx_reg <= word_idx_next;
            wrapped_reg  <= wrapped_next;
            event_reg    <= event_next;
            ch_reg       <= ch_next;
            if (cmd.word_we)
            begin
                written_reg[word_idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.word_we)
        begin
            mem_store[word_idx_reg] <= word_code;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem_store[ch_reg];
            rd_hit_reg  <= written_reg[ch_reg];
        end
    end

    assign rd_code = rd_hit_reg ? rd_data_reg : '0;

    // scale: (code * gain) >> 12, minus offset
    assign uv_next = tbsfd_pkg::UV_W'(prod_reg[tbsfd_pkg::PROD_W-1:tbsfd_pkg::SCALE_SHIFT])
                   - tbsfd_pkg::UV_W'(offset_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= tbsfd_pkg::PROD_W'(rd_code) * tbsfd_pkg::PROD_W'(gain_reg);
        end
        if (cmd.out_load)
        begin
            channel_index        <= ch_reg;
            sample_code          <= rd_code;
            sample_microvolts_q4 <= signed'(uv_next);
            event_code           <= event_reg;
            last                 <= status.last_ch;
        end
    end

endmodule

[rtl/three_byte_sample_frame_deframer.sv]
// a word without the frame mark is taken while idle, and the next word may follow at once
// frame end: each sample walks the read, multiply and load states before it is offered, and the
// next one starts once the prior one is taken, paced by the shared read, multiply, scale path
// input stalls for the whole flush; the next word is taken the cycle after the last sample
// reset (rst_n low, async): index, wrap flag, event code and control clear, store reads as zeros,
// gain and offset return to their defaults
module three_byte_sample_frame_deframer #(
    parameter int CHANNELS = tbsfd_pkg::CHANNELS_DEF,
    parameter int IDX_W    = $clog2(CHANNELS)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input request: one three-byte word
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         first_byte,
    input  logic [7:0]                         second_byte,
    input  logic [7:0]                         third_byte,
    // output request: one channel sample
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [IDX_W-1:0]                   channel_index,
    output logic [tbsfd_pkg::CODE_W-1:0]       sample_code,
    output logic signed [tbsfd_pkg::UV_W-1:0]  sample_microvolts_q4,
    output logic [tbsfd_pkg::EVENT_W-1:0]      event_code,
    output logic                               last,
    // configuration writes
    input  logic                               cfg_we,
    input  logic [tbsfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbsfd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // command and status between sequencer and datapath
    tbsfd_pkg::ctrl_cmd_t  cmd;
    tbsfd_pkg::dp_status_t status;

    // sequencer: idle takes words, flush walks read, multiply, load, hand-off per channel
    tbsfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: sample store, word index, event bits, scaling and output registers
    tbsfd_dp #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .status               (status),
        .first_byte           (first_byte),
        .second_byte          (second_byte),
        .third_byte           (third_byte),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .channel_index        (channel_index),
        .sample_code          (sample_code),
        .sample_microvolts_q4 (sample_microvolts_q4),
        .event_code           (event_code),
        .last                 (last)
    );

endmodule
